// ===== design/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

    localparam int MAX_OBJECTS = 64;
    localparam int ARENA_MAX   = 1048576;
    localparam int ALIGN_BYTES = 16;
    localparam int SLOTS       = MAX_OBJECTS * 2 + 1;

    localparam int SIZE_W  = 21;
    localparam int OFF_W   = 20;
    localparam int LINK_W  = 8;
    localparam int SEAL_W  = 32;
    localparam int CNT_W   = 13;
    localparam int REQ_W   = 32;

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(SLOTS);
    localparam logic [LINK_W-1:0] LAST_IDX = LINK_W'(SLOTS - 1);
    localparam logic [SEAL_W-1:0] SEAL_KEY = 32'h5243_4831;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NULL  = 2'd1;
    localparam logic [1:0] ST_OOM   = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_FREE    = 2'd1;
    localparam logic [1:0] FN_REALLOC = 2'd2;
    localparam logic [1:0] FN_NONE    = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] off;
        logic [SIZE_W-1:0] span;
        logic [SIZE_W-1:0] req;
        logic [LINK_W-1:0] link;
        logic [SEAL_W-1:0] seal;
    } rec_t;

    function automatic logic [SEAL_W-1:0] seal_of(input rec_t r);
        return ~({11'b0, r.off} ^ {11'b0, r.span} ^ {11'b0, r.req} ^
                 {24'b0, r.link} ^ SEAL_KEY);
    endfunction

    function automatic rec_t sealed(input rec_t r);
        rec_t t;
        t      = r;
        t.seal = seal_of(r);
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== design/ffba_ram.sv =====
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/first_fit_block_allocator.sv =====
// First-fit block allocator with coalescing over an arena of up to 1 MiB.
// Request channel s_*: func (alloc/free/realloc), req_size, ptr_offset,
// ptr_is_null. Result channel m_*: status, offsets, copy info and counters,
// one result beat per request beat.
// Config channel cfg_*: one beat writes arena_size and rebuilds the table
// (one free block covering the arena, or nothing if the size is invalid);
// taken only while the sequencer is idle.
// Record table: 129 records in a single-port-write RAM with registered read;
// a valid bit per record makes never-written records read as zero, so reset
// and a config write need no clearing pass.
// Every table walk chases links one record per cycle. A request runs the
// validation walk over the chain, then the first-fit walk, plus a
// spare-record scan (up to 129) on a split, plus one or two lookup walks
// and the table writes for free/realloc. s_ready is low from acceptance
// until the result is registered.
// A stalled m_ready holds the result beat; the next request is accepted
// meanwhile and its result waits in the sequencer until the beat is taken.
// Reset clears the arena size, table, counters and the sticky fault.
`default_nettype none

module first_fit_block_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ffba_pkg::SIZE_W-1:0]   cfg_arena_size,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_func,
    input  wire logic [ffba_pkg::REQ_W-1:0]    s_req_size,
    input  wire logic [ffba_pkg::OFF_W-1:0]    s_ptr_offset,
    input  wire logic                          s_ptr_is_null,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [ffba_pkg::OFF_W-1:0]         m_result_offset,
    output logic [ffba_pkg::OFF_W-1:0]         m_copy_from,
    output logic [ffba_pkg::SIZE_W-1:0]        m_copy_bytes,
    output logic [ffba_pkg::CNT_W-1:0]         m_live_objects,
    output logic [ffba_pkg::SIZE_W-1:0]        m_live_bytes,
    output logic [ffba_pkg::SIZE_W-1:0]        m_peak_bytes
);
    import ffba_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CHK     = 13'b0000000000010,
        S_CHK_END = 13'b0000000000100,
        S_ASTART  = 13'b0000000001000,
        S_AWALK   = 13'b0000000010000,
        S_SPARE   = 13'b0000000100000,
        S_AWR1    = 13'b0000001000000,
        S_AWR2    = 13'b0000010000000,
        S_FSTART  = 13'b0000100000000,
        S_FIND    = 13'b0001000000000,
        S_REL_A   = 13'b0010000000000,
        S_REL_B   = 13'b0100000000000,
        S_REL_C   = 13'b1000000000000
    } state_t;

    // REL_D folded into a flag: clear the released record after a prev merge
    state_t state_reg, state_next;

    logic [SIZE_W-1:0] arena_reg;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic [SIZE_W-1:0] peak_reg, peak_next;
    logic              fault_reg, fault_next;
    logic [SLOTS-1:0]  vld_reg;
    logic              vq_reg;
    logic [LINK_W-1:0] cur_reg;

    logic [1:0]        func_reg, func_next;
    logic [REQ_W-1:0]  size_reg, size_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic              null_reg, null_next;

    logic [LINK_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] cov_reg, cov_next;
    logic [LINK_W-1:0] obj_reg, obj_next;
    logic [SIZE_W-1:0] bytes_reg, bytes_next;
    logic [SIZE_W-1:0] need_reg, need_next;

    rec_t              fnd_reg, fnd_next;
    logic [LINK_W-1:0] fidx_reg, fidx_next;
    rec_t              prev_reg, prev_next;
    logic [LINK_W-1:0] pidx_reg, pidx_next;
    rec_t              last_reg, last_next;
    logic [LINK_W-1:0] lidx_reg, lidx_next;
    logic [LINK_W-1:0] spare_reg, spare_next;
    logic              clr_reg, clr_next;

    logic [1:0]        status_reg, status_next;
    logic [OFF_W-1:0]  res_reg, res_next;
    logic [OFF_W-1:0]  cfrom_reg, cfrom_next;
    logic [SIZE_W-1:0] cbytes_reg, cbytes_next;
    logic [SIZE_W-1:0] old_reg, old_next;
    logic              refind_reg, refind_next;

    logic              load_out;
    logic              cfg_fire;
    logic              cfg_ok;
    logic [LINK_W-1:0] raddr;
    logic              we;
    logic [LINK_W-1:0] waddr;
    rec_t              wrec;
    logic [$bits(rec_t)-1:0] ram_rdata;
    rec_t              rd_rec;

    // a pending result or a config beat keeps the request side closed
    assign s_ready   = (state_reg == S_IDLE) && !clr_reg && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) && !clr_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_ok    = (cfg_arena_size >= SIZE_W'(ALIGN_BYTES)) &&
                       (cfg_arena_size <= SIZE_W'(ARENA_MAX)) &&
                       ((cfg_arena_size % ALIGN_BYTES) == '0);
    assign rd_rec    = vq_reg ? rec_t'(ram_rdata) : '0;

    ffba_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrec),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [SIZE_W-1:0] tot_t;
        logic              bad_t;
        logic              ok_t;
        rec_t              tmp;

        tot_t  = '0;
        bad_t  = 1'b0;
        ok_t   = 1'b0;
        tmp    = '0;

        state_next  = state_reg;
        raddr       = '0;
        we          = 1'b0;
        waddr       = '0;
        wrec        = '0;
        load_out    = 1'b0;
        live_next   = live_reg;
        total_next  = total_reg;
        peak_next   = peak_reg;
        fault_next  = fault_reg;
        func_next   = func_reg;
        size_next   = size_reg;
        off_next    = off_reg;
        null_next   = null_reg;
        cnt_next    = cnt_reg;
        cov_next    = cov_reg;
        obj_next    = obj_reg;
        bytes_next  = bytes_reg;
        need_next   = need_reg;
        fnd_next    = fnd_reg;
        fidx_next   = fidx_reg;
        prev_next   = prev_reg;
        pidx_next   = pidx_reg;
        last_next   = last_reg;
        lidx_next   = lidx_reg;
        spare_next  = spare_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        res_next    = res_reg;
        cfrom_next  = cfrom_reg;
        cbytes_next = cbytes_reg;
        old_next    = old_reg;
        refind_next = refind_reg;

        case (state_reg)
            S_IDLE: begin
                if (clr_reg) begin
                    // result waits here until the previous beat drains
                    if (!m_valid || m_ready) begin
                        load_out = 1'b1;
                        clr_next = 1'b0;
                    end
                end else if (s_valid && s_ready) begin
                    func_next   = s_func;
                    size_next   = s_req_size;
                    off_next    = s_ptr_offset;
                    null_next   = s_ptr_is_null;
                    status_next = ST_OK;
                    res_next    = '0;
                    cfrom_next  = '0;
                    cbytes_next = '0;
                    refind_next = 1'b0;
                    if (fault_reg) begin
                        status_next = ST_FAULT;
                        clr_next    = 1'b1;
                    end else if (s_func == FN_NONE) begin
                        status_next = ST_NULL;
                        clr_next    = 1'b1;
                    end else if (s_func == FN_FREE && s_ptr_is_null) begin
                        clr_next    = 1'b1;
                    end else if (arena_reg == '0) begin
                        state_next = S_CHK_END;
                    end else begin
                        raddr      = '0;
                        cnt_next   = '0;
                        cov_next   = '0;
                        obj_next   = '0;
                        bytes_next = '0;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK: begin
                bad_t = (rd_rec.seal != seal_of(rd_rec)) || (rd_rec.off != cov_reg) ||
                        (rd_rec.span == '0) || ((rd_rec.span % ALIGN_BYTES) != '0) ||
                        (rd_rec.span > arena_reg - cov_reg) ||
                        (rd_rec.req > rd_rec.span) || (cnt_reg >= LINK_W'(SLOTS)) ||
                        (rd_rec.link > LINK_END);
                if (bad_t) begin
                    fault_next  = 1'b1;
                    status_next = ST_FAULT;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    cov_next = cov_reg + rd_rec.span;
                    cnt_next = cnt_reg + 1'b1;
                    if (rd_rec.req != '0) begin
                        obj_next   = obj_reg + 1'b1;
                        bytes_next = bytes_reg + rd_rec.req;
                    end
                    if (rd_rec.link == LINK_END) begin
                        state_next = S_CHK_END;
                    end else begin
                        raddr = rd_rec.link;
                    end
                end
            end
            S_CHK_END: begin
                if (arena_reg == '0) begin
                    ok_t = (live_reg == '0) && (total_reg == '0) && (peak_reg == '0);
                end else begin
                    ok_t = (cov_reg == arena_reg) && ({5'b0, obj_reg} == live_reg) &&
                           (bytes_reg == total_reg) &&
                           (obj_reg <= LINK_W'(MAX_OBJECTS)) &&
                           (peak_reg >= bytes_reg) && (peak_reg <= arena_reg);
                end
                if (!ok_t) begin
                    fault_next  = 1'b1;
                    status_next = ST_FAULT;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else if (func_reg == FN_ALLOC || null_reg) begin
                    state_next = S_ASTART;
                end else begin
                    state_next = S_FSTART;
                end
            end
            S_ASTART: begin
                if (size_reg == '0) begin
                    status_next = ST_NULL;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else if (arena_reg == '0 || size_reg > {11'b0, arena_reg} ||
                             live_reg >= CNT_W'(MAX_OBJECTS)) begin
                    status_next = ST_OOM;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    need_next  = (size_reg[SIZE_W-1:0] + SIZE_W'(ALIGN_BYTES - 1)) &
                                 ~SIZE_W'(ALIGN_BYTES - 1);
                    raddr      = '0;
                    cnt_next   = '0;
                    state_next = S_AWALK;
                end
            end
            S_AWALK: begin
                if (rd_rec.req == '0 && rd_rec.span >= need_reg) begin
                    fnd_next  = rd_rec;
                    fidx_next = cur_reg;
                    if (rd_rec.span > need_reg) begin
                        raddr      = '0;
                        state_next = S_SPARE;
                    end else begin
                        state_next = S_AWR2;
                    end
                end else if (rd_rec.link >= LINK_END ||
                             cnt_reg + 1'b1 >= LINK_W'(SLOTS)) begin
                    status_next = ST_OOM;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    raddr    = rd_rec.link;
                end
            end
            S_SPARE: begin
                if (rd_rec.span == '0) begin
                    spare_next = cur_reg;
                    state_next = S_AWR1;
                end else if (cur_reg == LAST_IDX) begin
                    status_next = ST_OOM;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    raddr = cur_reg + 1'b1;
                end
            end
            S_AWR1: begin
                tmp.off  = fnd_reg.off + need_reg;
                tmp.span = fnd_reg.span - need_reg;
                tmp.req  = '0;
                tmp.link = fnd_reg.link;
                tmp.seal = '0;
                we       = 1'b1;
                waddr    = spare_reg;
                wrec     = sealed(tmp);
                fnd_next.link = spare_reg;
                fnd_next.span = need_reg;
                state_next    = S_AWR2;
            end
            S_AWR2: begin
                tmp      = fnd_reg;
                tmp.req  = size_reg[SIZE_W-1:0];
                we       = 1'b1;
                waddr    = fidx_reg;
                wrec     = sealed(tmp);
                live_next  = live_reg + 1'b1;
                tot_t      = total_reg + size_reg[SIZE_W-1:0];
                total_next = tot_t;
                if (tot_t > peak_reg) begin
                    peak_next = tot_t;
                end
                res_next = fnd_reg.off[OFF_W-1:0];
                if (func_reg == FN_REALLOC && !null_reg) begin
                    // moving realloc: look the old block up again, then release it
                    cfrom_next  = off_reg;
                    cbytes_next = old_reg;
                    refind_next = 1'b1;
                    state_next  = S_FSTART;
                end else begin
                    clr_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FSTART: begin
                if (arena_reg == '0 || {1'b0, off_reg} >= arena_reg) begin
                    fault_next  = 1'b1;
                    status_next = ST_FAULT;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    raddr      = '0;
                    cnt_next   = '0;
                    lidx_next  = LINK_END;
                    last_next  = '0;
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                if (rd_rec.off == {1'b0, off_reg} && rd_rec.req != '0) begin
                    fnd_next  = rd_rec;
                    fidx_next = cur_reg;
                    prev_next = last_reg;
                    pidx_next = lidx_reg;
                    if (refind_reg || func_reg == FN_FREE) begin
                        state_next = S_REL_A;
                    end else if (size_reg == '0) begin
                        status_next = ST_NULL;
                        state_next  = S_REL_A;
                    end else if (size_reg <= {11'b0, rd_rec.span}) begin
                        tmp        = rd_rec;
                        tmp.req    = size_reg[SIZE_W-1:0];
                        we         = 1'b1;
                        waddr      = cur_reg;
                        wrec       = sealed(tmp);
                        tot_t      = total_reg - rd_rec.req + size_reg[SIZE_W-1:0];
                        total_next = tot_t;
                        if (tot_t > peak_reg) begin
                            peak_next = tot_t;
                        end
                        res_next   = off_reg;
                        clr_next   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        old_next   = rd_rec.req;
                        state_next = S_ASTART;
                    end
                end else if (rd_rec.link >= LINK_END ||
                             cnt_reg + 1'b1 >= LINK_W'(SLOTS)) begin
                    fault_next  = 1'b1;
                    status_next = ST_FAULT;
                    clr_next    = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    last_next = rd_rec;
                    lidx_next = cur_reg;
                    cnt_next  = cnt_reg + 1'b1;
                    raddr     = rd_rec.link;
                end
            end
            S_REL_A: begin
                if (fnd_reg.link < LINK_END) begin
                    raddr = fnd_reg.link;
                end
                state_next = S_REL_B;
            end
            S_REL_B: begin
                total_next   = total_reg - fnd_reg.req;
                live_next    = live_reg - 1'b1;
                fnd_next.req = '0;
                if (fnd_reg.link < LINK_END && rd_rec.req == '0) begin
                    fnd_next.span = fnd_reg.span + rd_rec.span;
                    fnd_next.link = rd_rec.link;
                    we            = 1'b1;
                    waddr         = fnd_reg.link;
                    wrec          = '0;
                end
                state_next = S_REL_C;
            end
            S_REL_C: begin
                if (pidx_reg < LINK_END && prev_reg.req == '0) begin
                    tmp      = prev_reg;
                    tmp.span = prev_reg.span + fnd_reg.span;
                    tmp.link = fnd_reg.link;
                    we       = 1'b1;
                    waddr    = pidx_reg;
                    wrec     = sealed(tmp);
                    // released record is swallowed; clear it next
                    pidx_next = LINK_END;
                    fnd_next  = '0;
                end else begin
                    we         = 1'b1;
                    waddr      = fidx_reg;
                    wrec       = (fnd_reg.span == '0) ? '0 : sealed(fnd_reg);
                    clr_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_fire) begin
            we         = 1'b1;
            waddr      = '0;
            tmp.off    = '0;
            tmp.span   = cfg_arena_size;
            tmp.req    = '0;
            tmp.link   = LINK_END;
            tmp.seal   = '0;
            wrec       = sealed(tmp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            arena_reg <= '0;
            live_reg  <= '0;
            total_reg <= '0;
            peak_reg  <= '0;
            fault_reg <= 1'b0;
            vld_reg   <= '0;
            vq_reg    <= 1'b0;
            clr_reg   <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vq_reg    <= vld_reg[raddr];
            clr_reg   <= clr_next;
            if (cfg_fire) begin
                arena_reg <= cfg_ok ? cfg_arena_size : '0;
                live_reg  <= '0;
                total_reg <= '0;
                peak_reg  <= '0;
                fault_reg <= 1'b0;
                vld_reg   <= SLOTS'(cfg_ok);
            end else begin
                live_reg  <= live_next;
                total_reg <= total_next;
                peak_reg  <= peak_next;
                fault_reg <= fault_next;
                if (we) begin
                    vld_reg[waddr] <= 1'b1;
                end
            end
            if (load_out) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= raddr;
        func_reg   <= func_next;
        size_reg   <= size_next;
        off_reg    <= off_next;
        null_reg   <= null_next;
        cnt_reg    <= cnt_next;
        cov_reg    <= cov_next;
        obj_reg    <= obj_next;
        bytes_reg  <= bytes_next;
        need_reg   <= need_next;
        fnd_reg    <= fnd_next;
        fidx_reg   <= fidx_next;
        prev_reg   <= prev_next;
        pidx_reg   <= pidx_next;
        last_reg   <= last_next;
        lidx_reg   <= lidx_next;
        spare_reg  <= spare_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        cfrom_reg  <= cfrom_next;
        cbytes_reg <= cbytes_next;
        old_reg    <= old_next;
        refind_reg <= refind_next;
        if (load_out) begin
            m_status        <= status_reg;
            m_result_offset <= (status_reg == ST_OK) ? res_reg : '0;
            m_copy_from     <= (status_reg == ST_OK) ? cfrom_reg : '0;
            m_copy_bytes    <= (status_reg == ST_OK) ? cbytes_reg : '0;
            m_live_objects  <= live_reg;
            m_live_bytes    <= total_reg;
            m_peak_bytes    <= peak_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/ffba_checker.sv =====
`default_nettype none

module ffba_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [1:0]                  m_status,
    input wire logic [ffba_pkg::OFF_W-1:0]  m_result_offset,
    input wire logic [ffba_pkg::OFF_W-1:0]  m_copy_from,
    input wire logic [ffba_pkg::SIZE_W-1:0] m_copy_bytes,
    input wire logic [ffba_pkg::CNT_W-1:0]  m_live_objects,
    input wire logic [ffba_pkg::SIZE_W-1:0] m_live_bytes,
    input wire logic [ffba_pkg::SIZE_W-1:0] m_peak_bytes
);
    import ffba_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_result_offset) && $stable(m_live_bytes))
        else $error("stalled result beat changed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in flight");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |->
        m_result_offset == '0 && m_copy_from == '0 && m_copy_bytes == '0)
        else $error("failed request reports offsets");

    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_live_objects <= CNT_W'(MAX_OBJECTS) &&
        m_peak_bytes >= m_live_bytes)
        else $error("counters out of range");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire

// ===== bench/first_fit_block_allocator_test.sv =====
module first_fit_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int IDLE_LIMIT = 40000;
    localparam int unsigned NREC = SLOTS;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  result_offset;
        logic [OFF_W-1:0]  copy_from;
        logic [SIZE_W-1:0] copy_bytes;
        logic [CNT_W-1:0]  live_objects;
        logic [SIZE_W-1:0] live_bytes;
        logic [SIZE_W-1:0] peak_bytes;
    } alloc_result_t;

    class heap_scoreboard;
        int unsigned arena;
        int unsigned b_off[NREC];
        int unsigned b_span[NREC];
        int unsigned b_req[NREC];
        int unsigned b_link[NREC];
        int unsigned live_count, byte_total, byte_peak;
        bit fault;
        alloc_result_t pending[$];
        int errors, results, faults;

        function void configure(int unsigned value);
            int unsigned v;
            v = value & 32'h1FFFFF;
            if (v < ALIGN_BYTES || v > ARENA_MAX || v % ALIGN_BYTES != 0) v = 0;
            arena = v;
            for (int i = 0; i < NREC; i++) begin
                b_off[i] = 0; b_span[i] = 0; b_req[i] = 0; b_link[i] = 0;
            end
            live_count = 0; byte_total = 0; byte_peak = 0; fault = 0;
            if (v != 0) begin
                b_span[0] = v;
                b_link[0] = NREC;
            end
        endfunction

        function void clear_rec(int unsigned i);
            b_off[i] = 0; b_span[i] = 0; b_req[i] = 0; b_link[i] = 0;
        endfunction

        function int unsigned find_live(int unsigned off, output int unsigned prev);
            int unsigned at, pv, steps;
            at = 0; pv = NREC; steps = 0; prev = NREC;
            if (arena == 0 || off >= arena) return NREC;
            while (at < NREC && steps < NREC) begin
                steps++;
                if (b_off[at] == off && b_req[at] != 0) begin
                    prev = pv;
                    return at;
                end
                pv = at;
                at = b_link[at];
            end
            return NREC;
        endfunction

        function void release_blk(int unsigned idx, int unsigned prev);
            int unsigned nx;
            nx = b_link[idx];
            byte_total -= b_req[idx];
            live_count--;
            b_req[idx] = 0;
            if (nx < NREC && b_req[nx] == 0) begin
                b_span[idx] += b_span[nx];
                b_link[idx] = b_link[nx];
                clear_rec(nx);
            end
            if (prev < NREC && b_req[prev] == 0) begin
                b_span[prev] += b_span[idx];
                b_link[prev] = b_link[idx];
                clear_rec(idx);
            end
        endfunction

        function logic [1:0] first_fit(longint unsigned size, output int unsigned off);
            int unsigned span, at, steps, spare;
            off = 0;
            if (size == 0) return ST_NULL;
            if (arena == 0 || size > arena || live_count >= MAX_OBJECTS) return ST_OOM;
            span = int'((size + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES);
            at = 0; steps = 0;
            while (at < NREC && steps < NREC) begin
                steps++;
                if (b_req[at] == 0 && b_span[at] >= span) begin
                    if (b_span[at] > span) begin
                        spare = 0;
                        while (spare < NREC && b_span[spare] != 0) spare++;
                        if (spare == NREC) return ST_OOM;
                        b_off[spare] = b_off[at] + span;
                        b_span[spare] = b_span[at] - span;
                        b_req[spare] = 0;
                        b_link[spare] = b_link[at];
                        b_link[at] = spare;
                        b_span[at] = span;
                    end
                    b_req[at] = int'(size);
                    live_count++;
                    byte_total += int'(size);
                    if (byte_total > byte_peak) byte_peak = byte_total;
                    off = b_off[at];
                    return ST_OK;
                end
                at = b_link[at];
            end
            return ST_OOM;
        endfunction

        // The table here is built only by legal steps, so the pre-request
        // consistency walk of the block always passes.
        function void note(logic [1:0] fn, logic [31:0] size, logic [OFF_W-1:0] off,
                           logic is_null);
            alloc_result_t r;
            int unsigned res, idx, prev, old;
            res = 0; r = '0; r.status = ST_OK;
            if (fault) r.status = ST_FAULT;
            else if (fn == FN_NONE) r.status = ST_NULL;
            else if (fn == FN_FREE && is_null) r.status = ST_OK;
            else if (arena == 0 && !(fn == FN_ALLOC || is_null)) begin
                fault = 1; r.status = ST_FAULT;
            end else if (fn == FN_ALLOC || is_null) r.status = first_fit(size, res);
            else begin
                idx = find_live(off, prev);
                if (idx >= NREC) begin
                    fault = 1; r.status = ST_FAULT;
                end else if (fn == FN_FREE) release_blk(idx, prev);
                else if (size == 0) begin
                    release_blk(idx, prev);
                    r.status = ST_NULL;
                end else if (size <= b_span[idx]) begin
                    byte_total = byte_total - b_req[idx] + size;
                    b_req[idx] = size;
                    if (byte_total > byte_peak) byte_peak = byte_total;
                    res = off;
                end else begin
                    old = b_req[idx];
                    r.status = first_fit(size, res);
                    if (r.status == ST_OK) begin
                        idx = find_live(off, prev);
                        if (idx < NREC) release_blk(idx, prev);
                        r.copy_from = off;
                        r.copy_bytes = SIZE_W'(old);
                    end
                end
            end
            if (r.status == ST_OK) r.result_offset = OFF_W'(res);
            else begin
                r.copy_from = 0; r.copy_bytes = 0;
            end
            if (r.status == ST_FAULT) faults++;
            r.live_objects = CNT_W'(live_count);
            r.live_bytes = SIZE_W'(byte_total);
            r.peak_bytes = SIZE_W'(byte_peak);
            pending.push_back(r);
        endfunction

        function void check(alloc_result_t got);
            alloc_result_t e;
            results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status)
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            if (got.result_offset != e.result_offset)
                $display("%0t: result_offset exp %h got %h", $time, e.result_offset,
                         got.result_offset);
            if (got.copy_from != e.copy_from)
                $display("%0t: copy_from exp %h got %h", $time, e.copy_from, got.copy_from);
            if (got.copy_bytes != e.copy_bytes)
                $display("%0t: copy_bytes exp %0d got %0d", $time, e.copy_bytes,
                         got.copy_bytes);
            if (got.live_objects != e.live_objects)
                $display("%0t: live_objects exp %0d got %0d", $time, e.live_objects,
                         got.live_objects);
            if (got.live_bytes != e.live_bytes)
                $display("%0t: live_bytes exp %0d got %0d", $time, e.live_bytes,
                         got.live_bytes);
            if (got.peak_bytes != e.peak_bytes)
                $display("%0t: peak_bytes exp %0d got %0d", $time, e.peak_bytes,
                         got.peak_bytes);
            if (got != e) errors++;
        endfunction

        function int pick_live();
            int unsigned offs[$];
            int unsigned at, steps;
            at = 0; steps = 0;
            if (arena == 0) return -1;
            while (at < NREC && steps < NREC) begin
                steps++;
                if (b_req[at] != 0) offs.push_back(b_off[at]);
                at = b_link[at];
            end
            if (offs.size() == 0) return -1;
            return offs[$urandom_range(0, offs.size() - 1)];
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [SIZE_W-1:0] cfg_arena_size;
    logic s_valid, s_ready;
    logic [1:0] s_func;
    logic [REQ_W-1:0] s_req_size;
    logic [OFF_W-1:0] s_ptr_offset;
    logic s_ptr_is_null;
    logic m_valid, m_ready;
    alloc_result_t m_beat;

    heap_scoreboard sb;
    bit calm;
    int idle_cycles, cfg_writes;

    first_fit_block_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_arena_size(cfg_arena_size),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_req_size(s_req_size),
        .s_ptr_offset(s_ptr_offset), .s_ptr_is_null(s_ptr_is_null),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_beat.status), .m_result_offset(m_beat.result_offset),
        .m_copy_from(m_beat.copy_from), .m_copy_bytes(m_beat.copy_bytes),
        .m_live_objects(m_beat.live_objects), .m_live_bytes(m_beat.live_bytes),
        .m_peak_bytes(m_beat.peak_bytes)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        int burst;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                burst = $urandom_range(1, 17);
                repeat (burst) @(negedge aclk);
            end
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check(m_beat);
        if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("first_fit_block_allocator regression: fail");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send(logic [1:0] fn, logic [31:0] size, logic [OFF_W-1:0] off,
                        logic is_null);
        int burst;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            burst = $urandom_range(1, 17);
            repeat (burst) @(negedge aclk);
        end
        s_valid <= 1;
        s_func <= fn;
        s_req_size <= size;
        s_ptr_offset <= off;
        s_ptr_is_null <= is_null;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note(fn, size, off, is_null);
        @(negedge aclk);
    endtask

    task automatic write_arena(logic [SIZE_W-1:0] v);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_valid <= 1;
        cfg_arena_size <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.configure(v);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic random_item();
        int p, sel;
        int unsigned cap;
        logic [31:0] size;
        cap = (sb.arena > 16) ? sb.arena / 8 : 16;
        sel = $urandom_range(0, 15);
        if (sel == 0) size = 0;
        else if (sel == 1) size = $urandom();
        else if (sel == 2) size = sb.arena;
        else if (sel == 3) size = $urandom_range(1, sb.arena + 16);
        else size = $urandom_range(1, cap);
        p = sb.pick_live();
        sel = $urandom_range(0, 99);
        if (sel < 40 || (p < 0 && sel < 85)) send(FN_ALLOC, size, OFF_W'($urandom()), 1'b0);
        else if (sel < 70) send(FN_FREE, $urandom(), OFF_W'(p), 1'b0);
        else if (sel < 85) send(FN_REALLOC, size, OFF_W'(p), 1'b0);
        else if (sel < 90) send(FN_REALLOC, size, OFF_W'($urandom()), 1'b1);
        else if (sel < 94) send(FN_FREE, $urandom(), OFF_W'($urandom()), 1'b1);
        else if (sel < 98) send(FN_NONE, $urandom(), OFF_W'($urandom()), 1'($urandom()));
        else send(2'($urandom_range(0, 3)), $urandom(), OFF_W'($urandom()),
                  1'($urandom()));
    endtask

    initial begin
        logic [SIZE_W-1:0] arenas[10];
        sb = new();
        sb.configure(0);
        calm = 0; idle_cycles = 0; cfg_writes = 0;
        aresetn = 0;
        cfg_valid = 0; cfg_arena_size = 0;
        s_valid = 0; s_func = FN_ALLOC; s_req_size = 0; s_ptr_offset = 0; s_ptr_is_null = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // uninitialized arena
        send(FN_ALLOC, 16, 0, 0);
        send(FN_FREE, 0, 0, 1);
        send(FN_FREE, 0, 0, 0);
        write_arena(256);
        send(FN_ALLOC, 0, 0, 0);
        send(FN_ALLOC, 257, 0, 0);
        send(FN_ALLOC, 1, 0, 0);
        send(FN_ALLOC, 32, 0, 0);
        send(FN_REALLOC, 10, 0, 0);
        send(FN_REALLOC, 100, 16, 0);
        send(FN_REALLOC, 40, 0, 1);
        send(FN_FREE, 0, 0, 1);
        send(FN_NONE, 32'hFFFF_FFFF, 20'hFFFFF, 1);
        send(FN_REALLOC, 0, 0, 0);
        send(FN_FREE, 0, 48, 0);
        send(FN_ALLOC, 32'hFFFF_FFFF, 0, 0);
        send(FN_FREE, 0, 20'hFFFFF, 0);
        send(FN_ALLOC, 16, 0, 0);
        write_arena(16);
        send(FN_ALLOC, 16, 0, 0);
        send(FN_ALLOC, 1, 0, 0);
        send(FN_REALLOC, 16, 0, 0);
        send(FN_REALLOC, 17, 0, 0);
        send(FN_FREE, 0, 0, 0);

        arenas = '{4096, ARENA_MAX, 8, 1024, 21'd1048592, 65536,
                   21'h1FFFFF, 2048, 16, 4096};
        foreach (arenas[k]) begin
            write_arena(arenas[k]);
            if (k == 9) calm = 1;
            repeat (133) random_item();
        end
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        $display("covered %0d results over %0d arena writes, %0d heap faults",
                 sb.results, cfg_writes, sb.faults);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("first_fit_block_allocator regression: pass");
        else
            $display("first_fit_block_allocator regression: fail");
        $finish;
    end
endmodule
